FILE: rtl/interval_map_assign_lookup_top_assert.svh
// Assertion macros for the interval map block.
`ifndef INTERVAL_MAP_ASSIGN_LOOKUP_TOP_ASSERT_SVH
`define INTERVAL_MAP_ASSIGN_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define IMA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define IMA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ima_pkg.sv
// Shared types and constants of the interval map block.
`timescale 1ns / 1ps
package ima_pkg;
   localparam int ENTRIES     = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 8;
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int CNT_W       = $clog2(ENTRIES + 1);
   localparam int NEW_W       = $clog2(ENTRIES + 3);
   localparam int ADDR_W      = $clog2(2 * ENTRIES);
   localparam int WORD_W      = KEY_WIDTH + VALUE_WIDTH;
   localparam int STATUS_W    = 2;
   localparam int BCOUNT_W    = 5;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_ASSIGN = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic lt_lo;
      logic le_hi;
   } cmp_res_type;
endpackage

FILE: rtl/interval_map_assign_lookup_top.sv
// Top level of the interval map: sequencer, table banks and result port.
`timescale 1ns / 1ps
// The block holds a sorted table of up to ENTRIES boundaries (key, value).
// Raise start with a request while busy is low; the request is taken on
// that edge. Exactly one result beat follows on rsp_valid for one cycle
// and cannot be held off, so the receiver must take it when it appears.
// Empty assign ranges and lookups on an empty table answer in the next
// cycle. Otherwise the sequencer walks the stored boundaries one at a
// time through a single compare unit and a single memory read port,
// reading and then evaluating each, and answers from a final state.
// An assign streams its rebuilt table into the idle bank of a two-bank
// memory and flips banks at the end, so a table-full reject leaves the old
// table untouched. Write csr_wdata (initial value) only while idle.
module interval_map_assign_lookup_top import ima_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_type,
   input  logic [KEY_WIDTH-1:0]   req_key_begin,
   input  logic [KEY_WIDTH-1:0]   req_key_end,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [KEY_WIDTH-1:0]   req_lookup_key,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_read_value,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [BCOUNT_W-1:0]    rsp_boundary_count,
   input  logic                   csr_we,
   input  logic [VALUE_WIDTH-1:0] csr_wdata
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_EVAL = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // control state
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   bank_ff, bank_in;
   logic [VALUE_WIDTH-1:0] init_ff;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [NEW_W-1:0]       n_ff, n_in;
   logic                   bdone_ff, bdone_in;
   logic                   edone_ff, edone_in;
   logic                   virt_ff, virt_in;
   logic                   op_ff, op_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [KEY_WIDTH-1:0]   b_ff, b_in;
   logic [KEY_WIDTH-1:0]   e_ff, e_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [VALUE_WIDTH-1:0] last_ff, last_in;
   logic [VALUE_WIDTH-1:0] vend_ff, vend_in;
   logic [VALUE_WIDTH-1:0] rv_ff, rv_in;
   logic [VALUE_WIDTH-1:0] rsp_rv_ff, rsp_rv_in;
   logic [STATUS_W-1:0]    rsp_st_ff, rsp_st_in;
   logic [BCOUNT_W-1:0]    rsp_bc_ff, rsp_bc_in;

   // memory ports
   logic                   mem_we, mem_re;
   logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
   logic [WORD_W-1:0]      mem_wdata, mem_rdata;

   logic [KEY_WIDTH-1:0]   ent_key;
   logic [VALUE_WIDTH-1:0] ent_val;
   cmp_res_type            cmp;
   logic [CNT_W-1:0]       idx_nxt;
   logic                   fits;

   ima_ram #(
      .DEPTH  (2 * ENTRIES),
      .WIDTH  (WORD_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // an empty table reads as one boundary at key zero holding the initial value
   assign ent_key = virt_ff ? '0 : mem_rdata[WORD_W-1:VALUE_WIDTH];
   assign ent_val = virt_ff ? init_ff : mem_rdata[VALUE_WIDTH-1:0];

   ima_cmp u_cmp (
      .key (ent_key),
      .lo  (b_ff),
      .hi  (e_ff),
      .res (cmp)
   );

   assign idx_nxt = idx_ff + CNT_W'(1);
   assign fits    = n_ff <= NEW_W'(ENTRIES);

   // read the live bank, write the rebuilt table to the other one
   assign mem_re    = (state_ff == S_READ);
   assign mem_raddr = bank_ff ? ADDR_W'(ENTRIES) + ADDR_W'(idx_ff[IDX_W-1:0])
                              : ADDR_W'(idx_ff[IDX_W-1:0]);
   assign mem_waddr = bank_ff ? ADDR_W'(n_ff[IDX_W-1:0])
                              : ADDR_W'(ENTRIES) + ADDR_W'(n_ff[IDX_W-1:0]);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      bank_in      = bank_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      bdone_in     = bdone_ff;
      edone_in     = edone_ff;
      virt_in      = virt_ff;
      op_in        = op_ff;
      b_in         = b_ff;
      e_in         = e_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      vend_in      = vend_ff;
      rv_in        = rv_ff;
      rsp_valid_in = 1'b0;
      rsp_rv_in    = rsp_rv_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_bc_in    = rsp_bc_ff;
      mem_we       = 1'b0;
      mem_wdata    = {ent_key, ent_val};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_type;
               b_in     = req_key_begin;
               e_in     = (req_type == REQ_ASSIGN) ? req_key_end : req_lookup_key;
               val_in   = req_value;
               idx_in   = '0;
               n_in     = '0;
               bdone_in = 1'b0;
               edone_in = 1'b0;
               rv_in    = init_ff;
               vend_in  = init_ff;
               virt_in  = (count_ff == '0);
               cnt_in   = (count_ff == '0) ? CNT_W'(1) : count_ff;
               if (req_type == REQ_ASSIGN && req_key_begin >= req_key_end) begin
                  // empty range: answer at once, table untouched
                  rsp_valid_in = 1'b1;
                  rsp_rv_in    = '0;
                  rsp_st_in    = ST_EMPTY;
                  rsp_bc_in    = BCOUNT_W'(count_ff);
               end else if (req_type == REQ_LOOKUP && count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_rv_in    = init_ff;
                  rsp_st_in    = ST_DONE;
                  rsp_bc_in    = BCOUNT_W'(count_ff);
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (op_ff == REQ_LOOKUP) begin
               if (cmp.le_hi) begin
                  rv_in = ent_val;
               end
               idx_in   = idx_nxt;
               state_in = (idx_nxt == cnt_ff) ? S_FIN : S_READ;
            end else if (!bdone_ff && cmp.lt_lo) begin
               // boundary below the range: copy
               mem_we   = (n_ff < NEW_W'(ENTRIES));
               n_in     = n_ff + NEW_W'(1);
               last_in  = ent_val;
               vend_in  = ent_val;
               idx_in   = idx_nxt;
               state_in = (idx_nxt == cnt_ff) ? S_FIN : S_READ;
            end else if (!bdone_ff) begin
               // insert the begin boundary unless it merges with its left side
               bdone_in = 1'b1;
               if (!(n_ff != '0 && last_ff == val_ff)) begin
                  mem_we    = (n_ff < NEW_W'(ENTRIES));
                  mem_wdata = {b_ff, val_ff};
                  n_in      = n_ff + NEW_W'(1);
                  last_in   = val_ff;
               end
            end else if (!edone_ff && cmp.le_hi) begin
               // boundary inside the range: drop, keep its value for the end
               vend_in  = ent_val;
               idx_in   = idx_nxt;
               state_in = (idx_nxt == cnt_ff) ? S_FIN : S_READ;
            end else if (!edone_ff) begin
               edone_in = 1'b1;
               if (vend_ff != val_ff) begin
                  mem_we    = (n_ff < NEW_W'(ENTRIES));
                  mem_wdata = {e_ff, vend_ff};
                  n_in      = n_ff + NEW_W'(1);
               end
            end else begin
               // boundary above the range: copy
               mem_we   = (n_ff < NEW_W'(ENTRIES));
               n_in     = n_ff + NEW_W'(1);
               idx_in   = idx_nxt;
               state_in = (idx_nxt == cnt_ff) ? S_FIN : S_READ;
            end
         end
         S_FIN: begin
            if (op_ff == REQ_LOOKUP) begin
               rsp_valid_in = 1'b1;
               rsp_rv_in    = rv_ff;
               rsp_st_in    = ST_DONE;
               rsp_bc_in    = BCOUNT_W'(count_ff);
               state_in     = S_IDLE;
            end else if (!bdone_ff) begin
               bdone_in = 1'b1;
               if (!(n_ff != '0 && last_ff == val_ff)) begin
                  mem_we    = (n_ff < NEW_W'(ENTRIES));
                  mem_wdata = {b_ff, val_ff};
                  n_in      = n_ff + NEW_W'(1);
                  last_in   = val_ff;
               end
            end else if (!edone_ff) begin
               edone_in = 1'b1;
               if (vend_ff != val_ff) begin
                  mem_we    = (n_ff < NEW_W'(ENTRIES));
                  mem_wdata = {e_ff, vend_ff};
                  n_in      = n_ff + NEW_W'(1);
               end
            end else begin
               // commit by flipping banks, or drop the rebuilt table if it overflowed
               rsp_valid_in = 1'b1;
               rsp_rv_in    = '0;
               if (fits) begin
                  bank_in   = ~bank_ff;
                  count_in  = CNT_W'(n_ff);
                  rsp_st_in = ST_DONE;
                  rsp_bc_in = BCOUNT_W'(n_ff);
               end else begin
                  rsp_st_in = ST_FULL;
                  rsp_bc_in = BCOUNT_W'(count_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         init_ff      <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         n_ff         <= '0;
         bdone_ff     <= 1'b0;
         edone_ff     <= 1'b0;
         virt_ff      <= 1'b0;
         op_ff        <= REQ_LOOKUP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         bdone_ff     <= bdone_in;
         edone_ff     <= edone_in;
         virt_ff      <= virt_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            init_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      b_ff      <= b_in;
      e_ff      <= e_in;
      val_ff    <= val_in;
      last_ff   <= last_in;
      vend_ff   <= vend_in;
      rv_ff     <= rv_in;
      rsp_rv_ff <= rsp_rv_in;
      rsp_st_ff <= rsp_st_in;
      rsp_bc_ff <= rsp_bc_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_rv_ff;
   assign rsp_status         = rsp_st_ff;
   assign rsp_boundary_count = rsp_bc_ff;
endmodule

FILE: rtl/ima_ram.sv
// Table memory with one write port, one read port and registered read data.
`timescale 1ns / 1ps
module ima_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 40,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/ima_cmp.sv
// Key compare unit shared by every scan step.
`timescale 1ns / 1ps
module ima_cmp import ima_pkg::*; (
   input  logic [KEY_WIDTH-1:0] key,
   input  logic [KEY_WIDTH-1:0] lo,
   input  logic [KEY_WIDTH-1:0] hi,
   output cmp_res_type          res
);
   // lower bound is strict, upper bound inclusive
   assign res.lt_lo = key < lo;
   assign res.le_hi = key <= hi;
endmodule

FILE: rtl/ima_checker.sv
// Port-level checker for the interval map block, bound to the top level.
`timescale 1ns / 1ps
`include "interval_map_assign_lookup_top_assert.svh"
module ima_checker import ima_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   req_type,
   input logic [KEY_WIDTH-1:0]   req_key_begin,
   input logic [KEY_WIDTH-1:0]   req_key_end,
   input logic                   rsp_valid,
   input logic [VALUE_WIDTH-1:0] rsp_read_value,
   input logic [STATUS_W-1:0]    rsp_status,
   input logic [BCOUNT_W-1:0]    rsp_boundary_count
);
   logic status_ok;
   logic count_ok;
   logic not_done;
   logic empty_req;
   logic empty_rsp;

   assign status_ok = rsp_status == ST_DONE || rsp_status == ST_EMPTY ||
                      rsp_status == ST_FULL;
   assign count_ok  = rsp_boundary_count <= BCOUNT_W'(ENTRIES);
   assign not_done  = rsp_valid && rsp_status != ST_DONE;
   assign empty_req = start && !busy && req_type == REQ_ASSIGN &&
                      req_key_begin >= req_key_end;
   assign empty_rsp = rsp_valid && rsp_status == ST_EMPTY;

   `IMA_ASSERT_NOW(a_status_code, rsp_valid, status_ok, "bad status code")
   `IMA_ASSERT_NOW(a_count_bound, rsp_valid, count_ok, "boundary count above table size")
   `IMA_ASSERT_NOW(a_reject_zero, not_done, rsp_read_value == '0, "nonzero value on assign beat")
   `IMA_ASSERT_NEXT(a_empty_range, empty_req, empty_rsp, "empty range not answered next cycle")
endmodule

bind interval_map_assign_lookup_top ima_checker u_ima_checker (.*);
